// ----- hdl/lkvc_pkg.sv -----
// Package for the LRU key/value cache: sizes, entry and cell control types, state codes.
package lkvc_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CFG_W      = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = 8;
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic compare;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

endpackage

// ----- hdl/lkvc_cell.sv -----
// One cell of the recency chain: holds an entry, compares its key, loads from its neighbour.
module lkvc_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lkvc_pkg::cell_ctl_t             ctl,
  input  logic [lkvc_pkg::KEY_BITS-1:0]   cmp_key,
  input  lkvc_pkg::entry_t                shift_in,
  output lkvc_pkg::entry_t                entry,
  output logic                            match
);

  logic                            valid_r;
  logic                            match_r;
  logic [lkvc_pkg::KEY_BITS-1:0]   key_r;
  logic [lkvc_pkg::VALUE_BITS-1:0] value_r;

  // Hold valid mark and compare result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        valid_r <= shift_in.valid;
      end
      if (ctl.compare) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  // Take key and value from the neighbour on a shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r   <= shift_in.key;
      value_r <= shift_in.value;
    end
  end

  assign entry.valid = valid_r;
  assign entry.key   = key_r;
  assign entry.value = value_r;
  assign match       = match_r;

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// An accepted word is handled as a compare step across the cell chain, then a shift step that
// writes its result to the output register; no new word is taken until the shift step is done.
// The shift step waits while a finished result is still stalled at the output register.
// Reset (synchronous, rst_n low) clears all valid marks, the occupancy count and the
// output valid flag, and sets the capacity limit to 16.
module lru_key_value_cache (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic        [lkvc_pkg::KEY_BITS-1:0]   in_lookup_key,
  input  logic signed [lkvc_pkg::VALUE_BITS-1:0] in_write_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic signed [lkvc_pkg::VALUE_BITS-1:0] out_read_value,
  output logic                                   out_evicted,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [lkvc_pkg::CFG_W-1:0]      cfg_data
);

  lkvc_pkg::state_t                state_r;
  logic                            op_r;
  logic [lkvc_pkg::KEY_BITS-1:0]   key_r;
  logic [lkvc_pkg::VALUE_BITS-1:0] wval_r;
  logic [lkvc_pkg::CNT_W-1:0]      occ_r;
  logic [lkvc_pkg::CNT_W-1:0]      occ_nxt;
  logic [lkvc_pkg::CFG_W-1:0]      cap_r;
  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [lkvc_pkg::VALUE_BITS-1:0] out_rd_r;
  logic                            out_ev_r;

  lkvc_pkg::entry_t                entries [lkvc_pkg::CAPACITY];
  lkvc_pkg::entry_t                new_entry;
  lkvc_pkg::cell_ctl_t             ctl [lkvc_pkg::CAPACITY];
  logic [lkvc_pkg::CAPACITY-1:0]   match_vec;
  logic [lkvc_pkg::CAPACITY-1:0]   valid_vec;

  logic                            in_acc;
  logic                            go;
  logic                            hit;
  logic [lkvc_pkg::IDX_W-1:0]      hit_pos;
  logic [lkvc_pkg::VALUE_BITS-1:0] hit_value;
  logic [lkvc_pkg::CMP_W-1:0]      cap_ext;
  logic [lkvc_pkg::CMP_W-1:0]      eff_cap;
  logic [lkvc_pkg::CMP_W-1:0]      occ_ext;
  logic                            evict;
  logic                            update;
  logic [lkvc_pkg::IDX_W-1:0]      shift_lim;

  assign in_stall  = (state_r != lkvc_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign go        = (state_r == lkvc_pkg::ST_UPDATE) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  // Chain of cells: cell 0 takes the new entry, each other cell its lower-numbered neighbour
  for (genvar g = 0; g < lkvc_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkvc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[g]),
        .cmp_key  (in_lookup_key),
        .shift_in (new_entry),
        .entry    (entries[g]),
        .match    (match_vec[g])
      );
    end else begin : g_body
      lkvc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[g]),
        .cmp_key  (in_lookup_key),
        .shift_in (entries[g-1]),
        .entry    (entries[g]),
        .match    (match_vec[g])
      );
    end
    assign valid_vec[g]   = entries[g].valid;
    assign ctl[g].compare = in_acc;
    assign ctl[g].load    = go && update && (lkvc_pkg::IDX_W'(g) <= shift_lim);
  end

  // Find the matching cell and select its value
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = lkvc_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_pos = lkvc_pkg::IDX_W'(i);
      end
    end
    for (int i = 0; i < lkvc_pkg::CAPACITY; i++) begin
      hit_value = hit_value | (entries[i].value & {lkvc_pkg::VALUE_BITS{match_vec[i]}});
    end
  end

  assign hit = |match_vec;

  // Clamp the capacity and decide on eviction
  always_comb begin
    cap_ext = lkvc_pkg::CMP_W'(cap_r);
    occ_ext = lkvc_pkg::CMP_W'(occ_r);
    if (cap_ext == '0) begin
      eff_cap = lkvc_pkg::CMP_W'(1);
    end else if (cap_ext > lkvc_pkg::CMP_W'(lkvc_pkg::CAPACITY)) begin
      eff_cap = lkvc_pkg::CMP_W'(lkvc_pkg::CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict  = op_r && !hit && (occ_ext >= eff_cap) && (occ_r != '0);
  assign update = op_r || hit;

  // Last cell that moves: the hit slot, the last slot on eviction, else the first free slot
  always_comb begin
    if (hit) begin
      shift_lim = hit_pos;
    end else if (evict) begin
      shift_lim = lkvc_pkg::IDX_W'(occ_r - lkvc_pkg::CNT_W'(1));
    end else begin
      shift_lim = lkvc_pkg::IDX_W'(occ_r);
    end
  end

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = key_r;
  assign new_entry.value = op_r ? wval_r : hit_value;

  // Occupancy grows only on a new-key put that does not evict
  always_comb begin
    occ_nxt = occ_r;
    if (go && op_r && !hit && !evict) begin
      occ_nxt = occ_r + lkvc_pkg::CNT_W'(1);
    end
  end

  // Sequence: compare cycle, then shift cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkvc_pkg::ST_IDLE;
      occ_r   <= '0;
      cap_r   <= lkvc_pkg::CAP_RESET;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      case (state_r)
        lkvc_pkg::ST_IDLE: begin
          if (in_acc) begin
            state_r <= lkvc_pkg::ST_UPDATE;
          end
        end
        lkvc_pkg::ST_UPDATE: begin
          if (go) begin
            state_r <= lkvc_pkg::ST_IDLE;
          end
        end
        default: begin
          state_r <= lkvc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_operation;
      key_r  <= in_lookup_key;
      wval_r <= $unsigned(in_write_value);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_hit_r <= hit;
      out_rd_r  <= (!op_r && hit) ? hit_value : '1;
      out_ev_r  <= evict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = $signed(out_rd_r);
  assign out_evicted    = out_ev_r;

`ifndef ASSERT_OFF
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkvc_pkg::ST_UPDATE) |-> $onehot0(match_vec))
    else $error("more than one cell matches the key");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(occ_r))
    else $error("valid marks disagree with occupancy");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= lkvc_pkg::CNT_W'(lkvc_pkg::CAPACITY))
    else $error("occupancy above capacity");

  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == lkvc_pkg::ST_UPDATE))
    else $error("accepted word did not start an update");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit)
    else $error("eviction reported on a hit");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for lru_key_value_cache: directed table, random phases, shadow LRU model.
`timescale 1ns / 1ps

module tb_top;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [lkvc_pkg::VALUE_BITS-1:0] NO_VALUE = '1;
  localparam int PLAN_ROWS   = 25;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 43;
  localparam int POOL_MAX    = 24;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SQUEEZE_AT  = 200;
  localparam int SQUEEZE_LEN = 90;

  typedef struct packed {
    logic                            hit;
    logic [lkvc_pkg::VALUE_BITS-1:0] read_value;
    logic                            evicted;
  } reply_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [lkvc_pkg::CFG_W-1:0]      cap;
    logic                            op;
    logic [lkvc_pkg::KEY_BITS-1:0]   key;
    logic [lkvc_pkg::VALUE_BITS-1:0] wval;
    logic                            fixed;
    reply_t                          reply;
  } plan_row_t;

  localparam reply_t MISS_REPLY = '{1'b0, NO_VALUE, 1'b0};

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic                                   in_operation = 1'b0;
  logic        [lkvc_pkg::KEY_BITS-1:0]   in_lookup_key = '0;
  logic signed [lkvc_pkg::VALUE_BITS-1:0] in_write_value = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic                                   out_hit;
  logic signed [lkvc_pkg::VALUE_BITS-1:0] out_read_value;
  logic                                   out_evicted;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic        [lkvc_pkg::CFG_W-1:0]      cfg_data = '0;

  // Shadow copy of the cache contents, slot 0 most recent
  logic [lkvc_pkg::KEY_BITS-1:0]   shadow_key   [lkvc_pkg::CAPACITY];
  logic [lkvc_pkg::VALUE_BITS-1:0] shadow_value [lkvc_pkg::CAPACITY];
  logic                            shadow_valid [lkvc_pkg::CAPACITY];
  int                              shadow_fill;
  logic [lkvc_pkg::CFG_W-1:0]      shadow_cap;

  reply_t pending_replies[$];
  int     mismatch_count = 0;
  int     replies_taken = 0;
  bit     eager = 1'b0;
  bit     sink_calm = 1'b0;
  int unsigned cycle_count = 0;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Move one slot to the front, shifting the more recent ones down
  function automatic void move_to_front(input int pos);
    logic [lkvc_pkg::KEY_BITS-1:0]   k;
    logic [lkvc_pkg::VALUE_BITS-1:0] v;
    int                              i;
    k = shadow_key[pos];
    v = shadow_value[pos];
    for (i = pos; i > 0; i--) begin
      shadow_key[i]   = shadow_key[i-1];
      shadow_value[i] = shadow_value[i-1];
      shadow_valid[i] = shadow_valid[i-1];
    end
    shadow_key[0]   = k;
    shadow_value[0] = v;
    shadow_valid[0] = 1'b1;
  endfunction

  // Apply one get or put to the shadow cache and return the reply it gives
  function automatic reply_t cache_access(input logic op,
                                          input logic [lkvc_pkg::KEY_BITS-1:0] key,
                                          input logic [lkvc_pkg::VALUE_BITS-1:0] val);
    reply_t r;
    int     pos;
    int     lim;
    int     i;
    bit     found;
    r = MISS_REPLY;
    found = 1'b0;
    pos = 0;
    for (i = 0; i < shadow_fill; i++) begin
      if (!found && shadow_valid[i] && shadow_key[i] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (op == OP_GET) r.read_value = shadow_value[pos];
      else shadow_value[pos] = val;
      move_to_front(pos);
    end else if (op == OP_PUT) begin
      // Clamp the limit: zero acts as one, above size acts as size
      lim = int'(shadow_cap);
      if (lim == 0) lim = 1;
      if (lim > lkvc_pkg::CAPACITY) lim = lkvc_pkg::CAPACITY;
      if (shadow_fill >= lim && shadow_fill > 0) begin
        shadow_fill--;
        shadow_valid[shadow_fill] = 1'b0;
        r.evicted = 1'b1;
      end
      shadow_key[shadow_fill]   = key;
      shadow_value[shadow_fill] = val;
      shadow_valid[shadow_fill] = 1'b1;
      move_to_front(shadow_fill);
      shadow_fill++;
    end
    return r;
  endfunction

  // Directed table: typed replies where they are obvious, shadow model otherwise
  function automatic plan_row_t plan_row(input int n);
    plan_row_t r;
    case (n)
      0:  r = '{ROW_WORD, 5'd0,  OP_GET, 32'h0, 32'h0, 1'b1, MISS_REPLY};
      1:  r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h0, 32'h1234_5678, 1'b1, MISS_REPLY};
      2:  r = '{ROW_WORD, 5'd0,  OP_GET, 32'h0, 32'h0, 1'b1, '{1'b1, 32'h1234_5678, 1'b0}};
      3:  r = '{ROW_WORD, 5'd0,  OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, MISS_REPLY};
      4:  r = '{ROW_WORD, 5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
                '{1'b1, 32'h7FFF_FFFF, 1'b0}};
      5:  r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h0, 32'h8000_0000, 1'b1, '{1'b1, NO_VALUE, 1'b0}};
      6:  r = '{ROW_WORD, 5'd0,  OP_GET, 32'h0, 32'hFFFF_FFFF, 1'b1,
                '{1'b1, 32'h8000_0000, 1'b0}};
      7:  r = '{ROW_WORD, 5'd0,  OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, MISS_REPLY};
      8:  r = '{ROW_WORD, 5'd0,  OP_GET, 32'h5555_5555, 32'h0, 1'b1, MISS_REPLY};
      // Limit below occupancy: every new key evicts one and inserts one
      9:  r = '{ROW_CFG,  5'd2,  OP_GET, 32'h0, 32'h0, 1'b0, MISS_REPLY};
      10: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h1, 32'h1, 1'b1, '{1'b0, NO_VALUE, 1'b1}};
      11: r = '{ROW_WORD, 5'd0,  OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, MISS_REPLY};
      12: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h2, 32'h2, 1'b1, '{1'b0, NO_VALUE, 1'b1}};
      13: r = '{ROW_WORD, 5'd0,  OP_GET, 32'h0, 32'h0, 1'b1, MISS_REPLY};
      14: r = '{ROW_WORD, 5'd0,  OP_GET, 32'hAAAA_AAAA, 32'h0, 1'b1,
                '{1'b1, 32'h5555_5555, 1'b0}};
      // Zero limit acts as one
      15: r = '{ROW_CFG,  5'd0,  OP_GET, 32'h0, 32'h0, 1'b0, MISS_REPLY};
      16: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h3, 32'h3, 1'b1, '{1'b0, NO_VALUE, 1'b1}};
      17: r = '{ROW_WORD, 5'd0,  OP_GET, 32'h1, 32'h0, 1'b1, MISS_REPLY};
      // Limit above size acts as size
      18: r = '{ROW_CFG,  5'd31, OP_GET, 32'h0, 32'h0, 1'b0, MISS_REPLY};
      19: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h4, 32'h4, 1'b1, MISS_REPLY};
      20: r = '{ROW_WORD, 5'd0,  OP_GET, 32'h2, 32'h0, 1'b1, '{1'b1, 32'h2, 1'b0}};
      21: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h4, 32'hFFFF_FFFF, 1'b1, '{1'b1, NO_VALUE, 1'b0}};
      22: r = '{ROW_WORD, 5'd0,  OP_GET, 32'h4, 32'h0, 1'b1, '{1'b1, NO_VALUE, 1'b0}};
      23: r = '{ROW_WORD, 5'd0,  OP_PUT, 32'h5555_AAAA, 32'h0F0F_0F0F, 1'b0, MISS_REPLY};
      default: r = '{ROW_WORD, 5'd0, OP_GET, 32'h3, 32'h0, 1'b0, MISS_REPLY};
    endcase
    return r;
  endfunction

  // Offer one word after a random gap unless eager, hold it until taken, then queue its expected reply
  task automatic drive_word(input logic op, input logic [lkvc_pkg::KEY_BITS-1:0] key,
                            input logic [lkvc_pkg::VALUE_BITS-1:0] val, input bit fixed,
                            input reply_t fixed_reply);
    int     gap;
    reply_t predicted;
    gap = eager ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation   <= op;
    in_lookup_key  <= key;
    in_write_value <= val;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cache_access(op, key, val);
    pending_replies.push_back(fixed ? fixed_reply : predicted);
  endtask

  // Drain every outstanding reply before touching the register
  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lkvc_pkg::CFG_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_cap = value;
    cfg_valid <= 1'b0;
  endtask

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Stimulus: reset, directed table, then random phases under varied limits
  initial begin : stimulus
    plan_row_t                     row;
    logic [lkvc_pkg::KEY_BITS-1:0] key_pool [POOL_MAX];
    int                            pool_size;
    int                            n;
    int                            p;
    int                            w;
    logic [lkvc_pkg::CFG_W-1:0]    cap;
    logic [lkvc_pkg::KEY_BITS-1:0] key;
    for (n = 0; n < lkvc_pkg::CAPACITY; n++) begin
      shadow_key[n]   = '0;
      shadow_value[n] = '0;
      shadow_valid[n] = 1'b0;
    end
    shadow_fill = 0;
    shadow_cap  = lkvc_pkg::CAP_RESET;
    pool_size   = 1;
    key_pool[0] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < PLAN_ROWS; n++) begin
      row = plan_row(n);
      if (row.kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_drained();
        write_capacity(row.cap);
      end else begin
        drive_word(row.op, row.key, row.wval, row.fixed, row.reply);
      end
    end
    in_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd4;
        3: cap = 5'd0;
        4: cap = 5'd17;
        5: cap = 5'd31;
        6: cap = 5'd8;
        9: cap = 5'd2;
        default: cap = lkvc_pkg::CFG_W'($urandom_range(0, 31));
      endcase
      wait_drained();
      write_capacity(cap);
      // Refresh the key pool now and then, keep it otherwise so old entries hit
      if (p == 0 || $urandom_range(0, 1) == 1) begin
        pool_size = $urandom_range(1, POOL_MAX);
        for (n = 0; n < pool_size; n++) key_pool[n] = $urandom();
      end
      eager = ($urandom_range(0, 3) == 0);
      for (w = 0; w < PHASE_WORDS; w++) begin
        if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom();
        drive_word(logic'($urandom_range(0, 1)), key, $urandom(), 1'b0, MISS_REPLY);
      end
      in_valid <= 1'b0;
    end

    // Wait out the tail and give the verdict
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Reply sink: random stalls, calm stretches, and one long hold-off
  initial begin : reply_sink
    reply_t exp;
    int     hold;
    bit     squeezed;
    hold = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply, hit %0b value %0d evicted %0b", $time,
                   out_hit, out_read_value, out_evicted);
          mismatch_count++;
        end else begin
          exp = pending_replies.pop_front();
          if (out_hit !== exp.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, exp.hit, out_hit);
            mismatch_count++;
          end
          if (out_read_value !== exp.read_value) begin
            $display("%0t: read_value expected %0d, got %0d", $time,
                     $signed(exp.read_value), out_read_value);
            mismatch_count++;
          end
          if (out_evicted !== exp.evicted) begin
            $display("%0t: evicted expected %0b, got %0b", $time, exp.evicted, out_evicted);
            mismatch_count++;
          end
        end
        replies_taken++;
        if (replies_taken % 40 == 0) sink_calm = !sink_calm;
        hold = sink_calm ? 0 : $urandom_range(0, 11);
        if (!squeezed && replies_taken == SQUEEZE_AT) begin
          squeezed = 1'b1;
          hold = SQUEEZE_LEN;
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
